FILE: rtl/image_orientation_transform_core_macros.svh
// Assertion shorthands used by the checker file.
`ifndef IMAGE_ORIENTATION_TRANSFORM_CORE_MACROS_SVH
`define IMAGE_ORIENTATION_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define IOT_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("iot assertion failed");

// Delayed implication, disabled while in reset.
`define IOT_ASSERT_D2(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
    else $error("iot assertion failed");

`endif

FILE: rtl/iot_pkg.sv
package iot_pkg;

  localparam int unsigned PixelW    = 32;
  localparam int unsigned CfgSideW  = 9;
  localparam int unsigned CfgSmallW = 3;
  localparam int unsigned CfgIdxW   = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH      = 3'd0,
    CFG_IMAGE_HEIGHT     = 3'd1,
    CFG_BYTES_PER_PIXEL  = 3'd2,
    CFG_ORIENTATION_MODE = 3'd3
  } cfg_idx_e;

  typedef enum logic [CfgSmallW-1:0] {
    ORIENT_ROT_CW    = 3'd0,
    ORIENT_ROT_CCW   = 3'd1,
    ORIENT_ROT_180   = 3'd2,
    ORIENT_FLIP_ROWS = 3'd3,
    ORIENT_FLIP_COLS = 3'd4
  } orient_e;

  typedef enum logic {
    ITEM_WRITE = 1'b0,
    ITEM_READ  = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [CfgSideW-1:0]  image_width;
    logic [CfgSideW-1:0]  image_height;
    logic [CfgSmallW-1:0] bytes_per_pixel;
    logic [CfgSmallW-1:0] orientation_mode;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic [PixelW-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel_out;
    logic              frame_end;
  } out_item_t;

endpackage

FILE: rtl/iot_ram.sv
module iot_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/iot_front.sv
module iot_front #(
  parameter int unsigned MAX_SIDE = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  iot_pkg::cfg_t                         cfg_i,
  input  logic                                  clear_i,
  input  logic                                  accept_i,
  input  iot_pkg::in_item_t                     item_i,
  output logic                                  is_read_o,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  addr_o,
  output logic [iot_pkg::PixelW-1:0]            data_o,
  output logic                                  last_o
);
  import iot_pkg::*;

  localparam int unsigned SideW  = $clog2(MAX_SIDE + 1);
  localparam int unsigned CoordW = $clog2(MAX_SIDE);
  localparam int unsigned AddrW  = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int unsigned CmpW   = (SideW > CfgSideW) ? SideW : CfgSideW;
  localparam int unsigned ProdW  = CoordW + SideW;
  localparam int unsigned AreaW  = 2 * SideW;

  logic [AddrW-1:0]  load_q, load_d;
  logic [CoordW-1:0] row_q, row_d, col_q, col_d;
  logic [SideW-1:0]  w, h, ow, oh;
  logic [CmpW-1:0]   w_raw, h_raw;
  logic              rotated;
  logic [SideW-1:0]  sx_full, sy_full;
  logic [CoordW-1:0] sx, sy;
  logic [ProdW-1:0]  rd_addr_full;
  logic [AreaW-1:0]  area, load_inc;
  logic [SideW-1:0]  col_inc, row_inc;

  // out-of-range sizes: zero acts as one, oversize acts as the maximum
  always_comb begin
    w_raw = CmpW'(cfg_i.image_width);
    h_raw = CmpW'(cfg_i.image_height);
    if (w_raw == '0) begin
      w = SideW'(1);
    end else if (w_raw > CmpW'(MAX_SIDE)) begin
      w = SideW'(MAX_SIDE);
    end else begin
      w = SideW'(w_raw);
    end
    if (h_raw == '0) begin
      h = SideW'(1);
    end else if (h_raw > CmpW'(MAX_SIDE)) begin
      h = SideW'(MAX_SIDE);
    end else begin
      h = SideW'(h_raw);
    end
  end

  assign rotated = (cfg_i.orientation_mode == ORIENT_ROT_CW) ||
                   (cfg_i.orientation_mode == ORIENT_ROT_CCW);
  assign ow = rotated ? h : w;
  assign oh = rotated ? w : h;

  // source coordinate of the current output position
  always_comb begin
    unique case (cfg_i.orientation_mode)
      ORIENT_ROT_CW: begin
        sx_full = SideW'(row_q);
        sy_full = h - SideW'(1) - SideW'(col_q);
      end
      ORIENT_ROT_CCW: begin
        sx_full = w - SideW'(1) - SideW'(row_q);
        sy_full = SideW'(col_q);
      end
      ORIENT_ROT_180: begin
        sx_full = w - SideW'(1) - SideW'(col_q);
        sy_full = h - SideW'(1) - SideW'(row_q);
      end
      ORIENT_FLIP_ROWS: begin
        sx_full = SideW'(col_q);
        sy_full = h - SideW'(1) - SideW'(row_q);
      end
      ORIENT_FLIP_COLS: begin
        sx_full = w - SideW'(1) - SideW'(col_q);
        sy_full = SideW'(row_q);
      end
      default: begin
        sx_full = SideW'(col_q);
        sy_full = SideW'(row_q);
      end
    endcase
  end

  assign sx = sx_full[CoordW-1:0];
  assign sy = sy_full[CoordW-1:0];
  assign rd_addr_full = ProdW'(sy) * ProdW'(w) + ProdW'(sx);

  assign area     = AreaW'(w) * AreaW'(h);
  assign load_inc = AreaW'(load_q) + AreaW'(1);
  assign col_inc  = SideW'(col_q) + SideW'(1);
  assign row_inc  = SideW'(row_q) + SideW'(1);

  assign is_read_o = (item_i.mode == ITEM_READ);
  assign addr_o    = is_read_o ? rd_addr_full[AddrW-1:0] : load_q;
  assign data_o    = item_i.pixel_in;
  assign last_o    = (row_inc == oh) && (col_inc == ow);

  always_comb begin
    load_d = load_q;
    row_d  = row_q;
    col_d  = col_q;
    priority if (clear_i) begin
      load_d = '0;
      row_d  = '0;
      col_d  = '0;
    end else if (accept_i && !is_read_o) begin
      load_d = (load_inc >= area) ? '0 : load_inc[AddrW-1:0];
    end else if (accept_i) begin
      if (col_inc >= ow) begin
        col_d = '0;
        row_d = (row_inc >= oh) ? '0 : row_inc[CoordW-1:0];
      end else begin
        col_d = col_inc[CoordW-1:0];
      end
    end else begin
      // idle cycle: counters hold
      load_d = load_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
    end else begin
      load_q <= load_d;
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

endmodule

FILE: rtl/iot_queue.sv
module iot_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(DEPTH));
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/iot_back.sv
module iot_back #(
  parameter int unsigned MAX_SIDE        = 256,
  parameter int unsigned MAX_PIXEL_BYTES = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [iot_pkg::CfgSmallW-1:0]        bytes_per_pixel_i,
  input  logic                                 job_valid_i,
  input  logic                                 is_read_i,
  input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] addr_i,
  input  logic [iot_pkg::PixelW-1:0]           data_i,
  input  logic                                 last_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  output iot_pkg::out_item_t                   result_o
);
  import iot_pkg::*;

  localparam int unsigned Depth = MAX_SIDE * MAX_SIDE;

  logic              valid_q, last_q;
  logic [PixelW-1:0] rdata, mask;
  logic [3:0]        eff_bytes;

  // the store never stalls, so the head job is taken in every cycle the queue holds one
  assign pop_o = job_valid_i;

  iot_ram #(
    .WIDTH(PixelW),
    .DEPTH(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (job_valid_i),
    .we_i   (!is_read_i),
    .addr_i (addr_i),
    .wdata_i(data_i),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= job_valid_i && is_read_i;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_i;
  end

  always_comb begin
    eff_bytes = (bytes_per_pixel_i == '0) ? 4'd1 : 4'(bytes_per_pixel_i);
    if (eff_bytes > 4'(MAX_PIXEL_BYTES)) begin
      eff_bytes = 4'(MAX_PIXEL_BYTES);
    end
    unique case (eff_bytes)
      4'd1:    mask = 32'h0000_00ff;
      4'd2:    mask = 32'h0000_ffff;
      4'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign out_valid_o        = valid_q;
  assign result_o.pixel_out = rdata & mask;
  assign result_o.frame_end = valid_q && last_q;

endmodule

FILE: rtl/image_orientation_transform_core.sv
// Frame-store orientation engine: rotate 90 cw/ccw, rotate 180, flip rows or columns.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 width,
//   1 height, 2 bytes per pixel, 3 mode) at once; any valid write restarts the
//   write and read counters. Write only while no item is in flight.
// Items: one is taken at each clock edge with start high and busy low.
//   mode 0 stores pixel_in at the next input raster position, no result.
//   mode 1 returns the next pixel of the transformed frame in output raster order.
// Results: out_valid_o is high for one cycle with result_o, after the read item has
//   passed the job queue and the store; frame_end marks the last output frame pixel.
//   The receiver cannot stall; every result must be taken when shown.
// Throughput: one item per cycle, set by the single-port frame store doing
//   one access per cycle; busy rises only if the two-entry job queue fills.
// Reset: counters clear and registers return to 256x256, 4 bytes, rotate cw.
//   The frame store is not cleared; read only what a full frame has written.
module image_orientation_transform_core #(
  parameter int unsigned MAX_SIDE        = 256,
  parameter int unsigned MAX_PIXEL_BYTES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iot_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [iot_pkg::CfgSideW-1:0]  cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  iot_pkg::in_item_t             item_i,
  output logic                          out_valid_o,
  output iot_pkg::out_item_t            result_o
);
  import iot_pkg::*;

  localparam int unsigned AddrW  = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int unsigned JobW   = 1 + AddrW + PixelW + 1;
  localparam int unsigned QDepth = 2;

  cfg_t              cfg_q;
  logic              cfg_hit, accept, full, empty, pop;
  logic              f_is_read, f_last, h_is_read, h_last;
  logic [AddrW-1:0]  f_addr, h_addr;
  logic [PixelW-1:0] f_data, h_data;
  logic [JobW-1:0]   head;

  assign accept = start && !busy;
  assign busy   = full;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT,
        CFG_BYTES_PER_PIXEL, CFG_ORIENTATION_MODE: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width      <= CfgSideW'(256);
      cfg_q.image_height     <= CfgSideW'(256);
      cfg_q.bytes_per_pixel  <= CfgSmallW'(4);
      cfg_q.orientation_mode <= ORIENT_ROT_CW;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:      cfg_q.image_width      <= cfg_data_i;
        CFG_IMAGE_HEIGHT:     cfg_q.image_height     <= cfg_data_i;
        CFG_BYTES_PER_PIXEL:  cfg_q.bytes_per_pixel  <= cfg_data_i[CfgSmallW-1:0];
        CFG_ORIENTATION_MODE: cfg_q.orientation_mode <= cfg_data_i[CfgSmallW-1:0];
        default: ;
      endcase
    end
  end

  iot_front #(
    .MAX_SIDE(MAX_SIDE)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .clear_i  (cfg_hit),
    .accept_i (accept),
    .item_i   (item_i),
    .is_read_o(f_is_read),
    .addr_o   (f_addr),
    .data_o   (f_data),
    .last_o   (f_last)
  );

  iot_queue #(
    .WIDTH(JobW),
    .DEPTH(QDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_data_i({f_is_read, f_addr, f_data, f_last}),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  assign {h_is_read, h_addr, h_data, h_last} = head;

  iot_back #(
    .MAX_SIDE       (MAX_SIDE),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .bytes_per_pixel_i(cfg_q.bytes_per_pixel),
    .job_valid_i      (!empty),
    .is_read_i        (h_is_read),
    .addr_i           (h_addr),
    .data_i           (h_data),
    .last_i           (h_last),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .result_o         (result_o)
  );

endmodule

FILE: rtl/iot_checker.sv
`include "image_orientation_transform_core_macros.svh"

module iot_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy_i,
  input iot_pkg::in_item_t  item_i,
  input logic               out_valid_i,
  input iot_pkg::out_item_t result_i
);
  import iot_pkg::*;

  logic read_taken, none_read;

  assign read_taken = start && !busy_i && (item_i.mode == ITEM_READ);
  assign none_read  = !read_taken;

  // each read item yields exactly one result
  `IOT_ASSERT_D2(a_read_gives_result, clk_i, rst_ni, read_taken, out_valid_i)
  // writes and idle cycles never produce a result
  `IOT_ASSERT_D2(a_no_spurious_result, clk_i, rst_ni, none_read, !out_valid_i)
  `IOT_ASSERT(a_frame_end_with_result, clk_i, rst_ni, result_i.frame_end, out_valid_i)

endmodule

bind image_orientation_transform_core iot_checker u_iot_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy_i     (busy),
  .item_i     (item_i),
  .out_valid_i(out_valid_o),
  .result_i   (result_o)
);
